FILE: rtl/core/kfs_pkg.sv
// Shared types and constants for the keyframe vec3 sampler.
// Holds the key row layout, the controller command / status structs and codes.
// No dependencies.
package kfs_pkg;

    // Key row layout in the key RAM: time, x, y, z from the low bits up
    localparam int COORD_W = 32;
    localparam int ROW_W   = 4 * COORD_W;
    localparam int ROW_T   = 0;
    localparam int ROW_X   = COORD_W;
    localparam int ROW_Y   = 2 * COORD_W;
    localparam int ROW_Z   = 3 * COORD_W;

    // Field widths of the request and result
    localparam int KEY_IDX_W = 6;
    localparam int SEG_W     = 6;
    localparam int KCOUNT_W  = 7;

    // Interpolation factor is unsigned Q0.16, one quotient bit per divide step
    localparam int FRAC_W    = 16;
    localparam int DIV_CNT_W = 4;

    // Default table depth
    localparam int MAX_KEYS_DEF = 64;

    // Request kind carried on tuser
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } kfs_axis_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             take_time;     // capture the sample time
        logic             load_prev;     // current RAM row becomes the segment start
        logic             load_key0;     // current RAM row is key 0, keep its position
        logic             load_next;     // current RAM row becomes the segment end
        logic             fallback_row;  // result is the position in the RAM row
        logic             fallback_key0; // result is the saved key 0 position
        logic             div_init;      // load remainder and span
        logic             div_step;      // one restoring divide step
        logic             delta;         // form end - start for the axis
        logic             mul;           // factor times delta
        logic             acc;           // start + scaled delta, saturate
        logic             emit;          // move the result into the output register
        kfs_axis_t        axis;
        logic [SEG_W-1:0] res_seg;
        logic             res_fb;
    } kfs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic t_lt_row;                  // sample time below the time in the RAM row
    } kfs_sts_t;

endpackage

FILE: rtl/core/kfs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module kfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/kfs_dpath.sv
// Datapath of the keyframe sampler: key RAM, segment registers, divider,
// shared multiplier and saturating adder, output register.
// Depends on kfs_pkg and kfs_ram.
module kfs_dpath import kfs_pkg::*; #(
    parameter int MAX_KEYS = MAX_KEYS_DEF,
    parameter int AW       = $clog2(MAX_KEYS)
) (
    input  logic               aclk,
    // key load
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ROW_W-1:0]   wr_row,
    // sample
    input  logic [COORD_W-1:0] samp_time,
    input  logic [AW-1:0]      rd_addr,
    input  kfs_cmd_t           cmd,
    output kfs_sts_t           sts,
    // result
    output logic [COORD_W-1:0] res_x,
    output logic [COORD_W-1:0] res_y,
    output logic [COORD_W-1:0] res_z,
    output logic [SEG_W-1:0]   res_seg,
    output logic               res_fb
);

    logic [ROW_W-1:0]          rd_row;
    logic [COORD_W-1:0]        samp_time_reg;
    logic [ROW_W-1:0]          prev_row_reg;
    logic [ROW_W-1:0]          next_row_reg;
    logic [ROW_W-1:ROW_X]      key0_reg;
    logic [COORD_W-1:0]        rem_reg;
    logic [COORD_W-1:0]        span_reg;
    logic [FRAC_W-1:0]         quo_reg;
    logic [COORD_W-1:0]        start_reg;
    logic signed [COORD_W:0]   delta_reg;
    logic signed [FRAC_W+COORD_W+1:0] prod_reg;
    logic [COORD_W-1:0]        work_reg [0:2];
    logic [COORD_W-1:0]        out_x_reg, out_y_reg, out_z_reg;
    logic [SEG_W-1:0]          out_seg_reg;
    logic                      out_fb_reg;

    logic [COORD_W:0]          shifted;
    logic [COORD_W+1:0]        trial;
    logic [COORD_W-1:0]        axis_a, axis_b;
    logic signed [COORD_W+2:0] sum;
    logic [COORD_W-1:0]        sat;

    kfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_row),
        .raddr (rd_addr),
        .rdata (rd_row)
    );

    assign sts.t_lt_row = samp_time_reg < rd_row[ROW_T +: COORD_W];

    // Divide step: shift remainder, try subtracting the span
    assign shifted = {rem_reg, 1'b0};
    assign trial   = {1'b0, shifted} - {2'b00, span_reg};

    // Pick start and end coordinate of the current axis
    always_comb begin
        case (cmd.axis)
            AXIS_X: begin
                axis_a = prev_row_reg[ROW_X +: COORD_W];
                axis_b = next_row_reg[ROW_X +: COORD_W];
            end
            AXIS_Y: begin
                axis_a = prev_row_reg[ROW_Y +: COORD_W];
                axis_b = next_row_reg[ROW_Y +: COORD_W];
            end
            AXIS_Z: begin
                axis_a = prev_row_reg[ROW_Z +: COORD_W];
                axis_b = next_row_reg[ROW_Z +: COORD_W];
            end
            default: begin
                axis_a = prev_row_reg[ROW_X +: COORD_W];
                axis_b = next_row_reg[ROW_X +: COORD_W];
            end
        endcase
    end

    // Start plus floor(product / 2^16), then clamp to 32 bits
    assign sum = $signed({{3{start_reg[COORD_W-1]}}, start_reg})
               + $signed({prod_reg[FRAC_W+COORD_W+1], prod_reg[FRAC_W+COORD_W+1:FRAC_W]});

    always_comb begin
        if (sum[COORD_W+2:COORD_W-1] == 4'b0000 || sum[COORD_W+2:COORD_W-1] == 4'b1111) begin
            sat = sum[COORD_W-1:0];
        end else if (sum[COORD_W+2]) begin
            sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    // Working registers, loaded on command
    always_ff @(posedge aclk) begin
        if (cmd.take_time) begin
            samp_time_reg <= samp_time;
        end
        if (cmd.load_prev) begin
            prev_row_reg <= rd_row;
        end
        if (cmd.load_key0) begin
            key0_reg <= rd_row[ROW_W-1:ROW_X];
        end
        if (cmd.load_next) begin
            next_row_reg <= rd_row;
        end
        if (cmd.div_init) begin
            rem_reg  <= samp_time_reg - prev_row_reg[ROW_T +: COORD_W];
            span_reg <= next_row_reg[ROW_T +: COORD_W] - prev_row_reg[ROW_T +: COORD_W];
            quo_reg  <= '0;
        end
        if (cmd.div_step) begin
            if (!trial[COORD_W+1]) begin
                rem_reg <= trial[COORD_W-1:0];
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[COORD_W-1:0];
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
            end
        end
        if (cmd.delta) begin
            start_reg <= axis_a;
            delta_reg <= $signed({axis_b[COORD_W-1], axis_b})
                       - $signed({axis_a[COORD_W-1], axis_a});
        end
        if (cmd.mul) begin
            prod_reg <= $signed({1'b0, quo_reg}) * delta_reg;
        end
        if (cmd.acc) begin
            work_reg[cmd.axis] <= sat;
        end
        if (cmd.fallback_row) begin
            work_reg[AXIS_X] <= rd_row[ROW_X +: COORD_W];
            work_reg[AXIS_Y] <= rd_row[ROW_Y +: COORD_W];
            work_reg[AXIS_Z] <= rd_row[ROW_Z +: COORD_W];
        end
        if (cmd.fallback_key0) begin
            work_reg[AXIS_X] <= key0_reg[ROW_X +: COORD_W];
            work_reg[AXIS_Y] <= key0_reg[ROW_Y +: COORD_W];
            work_reg[AXIS_Z] <= key0_reg[ROW_Z +: COORD_W];
        end
        if (cmd.emit) begin
            out_x_reg   <= work_reg[AXIS_X];
            out_y_reg   <= work_reg[AXIS_Y];
            out_z_reg   <= work_reg[AXIS_Z];
            out_seg_reg <= cmd.res_seg;
            out_fb_reg  <= cmd.res_fb;
        end
    end

    assign res_x   = out_x_reg;
    assign res_y   = out_y_reg;
    assign res_z   = out_z_reg;
    assign res_seg = out_seg_reg;
    assign res_fb  = out_fb_reg;

endmodule

FILE: rtl/core/kfs_ctrl.sv
// Controller of the keyframe sampler: key count register, segment search,
// divide and per-axis sequencing, output handshake.
// Depends on kfs_pkg.
module kfs_ctrl import kfs_pkg::*; #(
    parameter int MAX_KEYS = MAX_KEYS_DEF,
    parameter int AW       = $clog2(MAX_KEYS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [KCOUNT_W-1:0] cfg_wdata,
    input  logic                s_valid,
    input  logic                s_mode,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  kfs_sts_t            sts,
    output kfs_cmd_t            cmd,
    output logic [AW-1:0]       rd_addr
);

    localparam int NW = ($clog2(MAX_KEYS + 1) > KCOUNT_W) ? $clog2(MAX_KEYS + 1) : KCOUNT_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CHK0     = 9'b000000010,
        ST_SCAN     = 9'b000000100,
        ST_DIV_INIT = 9'b000001000,
        ST_DIV      = 9'b000010000,
        ST_DELTA    = 9'b000100000,
        ST_MUL      = 9'b001000000,
        ST_ACC      = 9'b010000000,
        ST_FIN      = 9'b100000000
    } kfs_state_t;

    kfs_state_t          state_reg, state_next;
    logic [KCOUNT_W-1:0] kcount_reg;
    logic [AW-1:0]       seg_reg, seg_next;
    logic                fb_reg, fb_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    kfs_axis_t           axis_reg, axis_next;
    logic                m_valid_reg, m_valid_next;
    logic [NW-1:0]       kc_ext;
    logic [NW-1:0]       n_eff;
    logic                last_key;

    // Clamp the key count to 1..MAX_KEYS
    assign kc_ext = NW'(kcount_reg);
    always_comb begin
        if (kc_ext == '0) begin
            n_eff = NW'(1);
        end else if (kc_ext > NW'(MAX_KEYS)) begin
            n_eff = NW'(MAX_KEYS);
        end else begin
            n_eff = kc_ext;
        end
    end

    // Row arriving in the scan is seg + 1; it is the last key in use
    assign last_key = (NW'(seg_reg) + NW'(2)) == n_eff;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Read address: key 0 when idle, then one row ahead of the compare
    always_comb begin
        case (state_reg)
            ST_CHK0: rd_addr = AW'(NW'(seg_reg) + NW'(1));
            ST_SCAN: rd_addr = AW'(NW'(seg_reg) + NW'(2));
            default: rd_addr = '0;
        endcase
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        fb_next      = fb_reg;
        dcnt_next    = dcnt_reg;
        axis_next    = axis_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.axis     = axis_reg;
        cmd.res_seg  = fb_reg ? '0 : SEG_W'(seg_reg);
        cmd.res_fb   = fb_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_mode == MODE_SAMPLE) begin
                    cmd.take_time = 1'b1;
                    seg_next      = '0;
                    fb_next       = 1'b0;
                    state_next    = ST_CHK0;
                end
            end
            ST_CHK0: begin
                cmd.load_prev = 1'b1;
                cmd.load_key0 = 1'b1;
                if (sts.t_lt_row || n_eff == NW'(1)) begin
                    cmd.fallback_row = 1'b1;
                    fb_next          = 1'b1;
                    state_next       = ST_FIN;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.t_lt_row) begin
                    cmd.load_next = 1'b1;
                    state_next    = ST_DIV_INIT;
                end else if (last_key) begin
                    cmd.fallback_key0 = 1'b1;
                    fb_next           = 1'b1;
                    state_next        = ST_FIN;
                end else begin
                    cmd.load_prev = 1'b1;
                    seg_next      = seg_reg + AW'(1);
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_CNT_W'(FRAC_W - 1)) begin
                    axis_next  = AXIS_X;
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA: begin
                cmd.delta  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                case (axis_reg)
                    AXIS_X:  begin axis_next = AXIS_Y; state_next = ST_DELTA; end
                    AXIS_Y:  begin axis_next = AXIS_Z; state_next = ST_DELTA; end
                    default: state_next = ST_FIN;
                endcase
            end
            ST_FIN: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kcount_reg  <= KCOUNT_W'(1);
            seg_reg     <= '0;
            fb_reg      <= 1'b0;
            dcnt_reg    <= '0;
            axis_reg    <= AXIS_X;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seg_reg     <= seg_next;
            fb_reg      <= fb_next;
            dcnt_reg    <= dcnt_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                kcount_reg <= cfg_wdata;
            end
        end
    end

endmodule

FILE: rtl/core/keyframe_vec3_sampler.sv
// Top level of the keyframe vec3 sampler: stream ports, request unpacking,
// controller and datapath. Depends on kfs_pkg, kfs_ctrl, kfs_dpath.
//
//   channel  dir  handshake          payload
//   s_       in   tvalid/tready      tuser: mode; tdata: key fields, sample time
//   m_       out  tvalid/tready      tuser: fell_back; tdata: x, y, z, segment
//   cfg_     in   cfg_we             cfg_wdata: key_count
//
// A load request writes its key row when it is accepted. A sample request is
// paced by the segment search, in which the key RAM read port visits one key
// a cycle, by the bit-serial divider and by one shared multiplier over three
// axes. A sample before the first key or with a single key skips the search
// and the arithmetic and goes straight to the result.
// Requests are taken only while idle; a finished result waits in the output
// register while the next request is taken. Reset is synchronous, active low.
module keyframe_vec3_sampler import kfs_pkg::*; #(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_we,
    input  logic [KCOUNT_W-1:0] cfg_wdata,
    // requests
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [167:0]        s_tdata,  // key_index, key_time, key_x, key_y, key_z,
                                          // sample_time, zero pad
    input  logic [0:0]          s_tuser,  // mode
    // results
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [103:0]        m_tdata,  // out_x, out_y, out_z, segment, zero pad
    output logic [0:0]          m_tuser   // fell_back
);

    localparam int AW = $clog2(MAX_KEYS);

    logic [KEY_IDX_W-1:0] key_index;
    logic [ROW_W-1:0]     key_row;
    logic [COORD_W-1:0]   sample_time;
    logic                 load_we;
    kfs_cmd_t             cmd;
    kfs_sts_t             sts;
    logic [AW-1:0]        rd_addr;
    logic [COORD_W-1:0]   res_x, res_y, res_z;
    logic [SEG_W-1:0]     res_seg;
    logic                 res_fb;

    // Unpack the request
    assign key_index   = s_tdata[5:0];
    assign key_row     = s_tdata[133:6];
    assign sample_time = s_tdata[165:134];

    // Write a key on a load request; drop slots beyond the table
    assign load_we = s_tvalid && s_tready && (s_tuser[0] == MODE_LOAD)
                     && (32'(key_index) < 32'(MAX_KEYS));

    kfs_ctrl #(
        .MAX_KEYS (MAX_KEYS),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_tvalid),
        .s_mode    (s_tuser[0]),
        .s_ready   (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .sts       (sts),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    kfs_dpath #(
        .MAX_KEYS (MAX_KEYS),
        .AW       (AW)
    ) u_dpath (
        .aclk      (aclk),
        .wr_en     (load_we),
        .wr_addr   (AW'(key_index)),
        .wr_row    (key_row),
        .samp_time (sample_time),
        .rd_addr   (rd_addr),
        .cmd       (cmd),
        .sts       (sts),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_z     (res_z),
        .res_seg   (res_seg),
        .res_fb    (res_fb)
    );

    // Pack the result
    assign m_tdata = {2'b00, res_seg, res_z, res_y, res_x};
    assign m_tuser = res_fb;

    // A taken sample request makes the block busy
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == MODE_SAMPLE |=> !s_tready)
        else $error("sample request taken while block stays ready");

    // A result moves into the output register only when it is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwrites an unsent result");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented");

    // A fallback result always reports segment zero
    a_fb_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[101:96] == '0)
        else $error("fallback result with nonzero segment");

endmodule

FILE: tb/tb_keyframe_vec3_sampler.sv
`timescale 1ns / 100ps
// Self-checking testbench for keyframe_vec3_sampler: loads keyframe tables, samples
// them and compares every result against an in-bench interpolation predictor.
// Depends on kfs_pkg and keyframe_vec3_sampler.
module tb_keyframe_vec3_sampler;
    import kfs_pkg::*;

    localparam int HOLD_OFF       = 128;   // longer than the longest sample
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_CAP      = 30;

    // One sampled position as the block reports it
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  seg;
        logic        fb;
    } pose_t;

    // Key table mirror, interpolation predictor and queue of expected positions
    class lerp_scoreboard;
        logic [31:0] t_tab[MAX_KEYS_DEF];
        logic [31:0] x_tab[MAX_KEYS_DEF];
        logic [31:0] y_tab[MAX_KEYS_DEF];
        logic [31:0] z_tab[MAX_KEYS_DEF];
        logic [KCOUNT_W-1:0] key_count;
        pose_t expected_poses[$];
        int errors, n_loads, n_samples, n_interp, n_fallback;

        function new();
            key_count = 1;
            for (int i = 0; i < MAX_KEYS_DEF; i++) begin
                t_tab[i] = '0;
                x_tab[i] = '0;
                y_tab[i] = '0;
                z_tab[i] = '0;
            end
        endfunction

        function void set_key_count(logic [KCOUNT_W-1:0] v);
            key_count = v;
        endfunction

        // start + floor(factor * (end - start) / 2^16), saturated to 32 bits
        function logic [31:0] lerp_axis(logic [31:0] a, logic [31:0] b, longint fac);
            longint s, d, r;
            s = longint'($signed(a));
            d = longint'($signed(b)) - s;
            r = s + ((fac * d) >>> 16);
            if (r > 64'sh7FFF_FFFF)
                r = 64'sh7FFF_FFFF;
            if (r < -64'sh8000_0000)
                r = -64'sh8000_0000;
            return r[31:0];
        endfunction

        function pose_t interpolate(logic [31:0] t);
            pose_t res;
            int n, seg, i;
            bit hit;
            longint span, diff, fac;
            n = key_count;
            if (n < 1)
                n = 1;
            if (n > MAX_KEYS_DEF)
                n = MAX_KEYS_DEF;
            hit = 0;
            seg = 0;
            // first segment whose end lies above t, only once t reached key 0
            if (t >= t_tab[0]) begin
                for (i = 0; i + 1 < n; i++) begin
                    if (!hit && t < t_tab[i+1]) begin
                        seg = i;
                        hit = 1;
                    end
                end
            end
            if (!hit) begin
                res = '{x: x_tab[0], y: y_tab[0], z: z_tab[0], seg: '0, fb: 1'b1};
                return res;
            end
            span = longint'(t_tab[seg+1]) - longint'(t_tab[seg]);
            diff = longint'(t) - longint'(t_tab[seg]);
            fac = 0;
            if (span > 0 && diff >= 0) begin
                fac = (diff <<< 16) / span;
                if (fac > 65535)
                    fac = 65535;
            end
            res.x   = lerp_axis(x_tab[seg], x_tab[seg+1], fac);
            res.y   = lerp_axis(y_tab[seg], y_tab[seg+1], fac);
            res.z   = lerp_axis(z_tab[seg], z_tab[seg+1], fac);
            res.seg = seg[5:0];
            res.fb  = 1'b0;
            return res;
        endfunction

        // Apply an accepted request: write a key or queue the predicted position
        function void note_request(logic mode, logic [5:0] idx, logic [31:0] kt,
                                   logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                                   logic [31:0] st);
            pose_t p;
            if (mode == MODE_LOAD) begin
                t_tab[idx] = kt;
                x_tab[idx] = kx;
                y_tab[idx] = ky;
                z_tab[idx] = kz;
                n_loads++;
            end else begin
                p = interpolate(st);
                expected_poses = {expected_poses, p};
                n_samples++;
                if (p.fb)
                    n_fallback++;
                else
                    n_interp++;
            end
        endfunction

        // Compare a delivered position with the oldest prediction
        function void check_result(pose_t got);
            pose_t want;
            bit bad;
            if (expected_poses.size() == 0) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: unexpected result x=%h y=%h z=%h seg=%0d fb=%0b",
                             $time, got.x, got.y, got.z, got.seg, got.fb);
                return;
            end
            want = expected_poses.pop_front();
            bad = (want.x !== got.x) || (want.y !== got.y) || (want.z !== got.z)
                  || (want.seg !== got.seg) || (want.fb !== got.fb);
            if (!bad)
                return;
            errors++;
            if (errors > PRINT_CAP)
                return;
            if (want.x !== got.x)
                $display("%0t: out_x expected %h got %h", $time, want.x, got.x);
            if (want.y !== got.y)
                $display("%0t: out_y expected %h got %h", $time, want.y, got.y);
            if (want.z !== got.z)
                $display("%0t: out_z expected %h got %h", $time, want.z, got.z);
            if (want.seg !== got.seg)
                $display("%0t: segment expected %0d got %0d", $time, want.seg, got.seg);
            if (want.fb !== got.fb)
                $display("%0t: fell_back expected %0b got %0b", $time, want.fb, got.fb);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [KCOUNT_W-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [167:0]        s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [103:0]        m_tdata;
    logic [0:0]          m_tuser;

    lerp_scoreboard sb;
    int src_idle;
    int sink_stall;
    int n_settings;
    int quiet_cycles;

    keyframe_vec3_sampler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Note every accepted request and check every accepted result
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser[0], s_tdata[5:0], s_tdata[37:6], s_tdata[69:38],
                            s_tdata[101:70], s_tdata[133:102], s_tdata[165:134]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{x: m_tdata[31:0], y: m_tdata[63:32], z: m_tdata[95:64],
                              seg: m_tdata[101:96], fb: m_tuser[0]});
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_keyframe_vec3_sampler: errors");
            $finish;
        end
    end

    // Offer one request, with random idle cycles ahead of it; return at a falling edge
    task automatic send_request(logic mode, logic [5:0] idx, logic [31:0] kt,
                                logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                                logic [31:0] st);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, st, kz, ky, kx, kt, idx};
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic load_key(logic [5:0] idx, logic [31:0] kt, logic [31:0] kx,
                            logic [31:0] ky, logic [31:0] kz);
        send_request(MODE_LOAD, idx, kt, kx, ky, kz, $urandom);
    endtask

    task automatic sample_at(logic [31:0] t);
        send_request(MODE_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, t);
    endtask

    // Hold the request side until all results are out, then let the block go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_poses.size() != 0)
            @(negedge aclk);
        repeat (HOLD_OFF) @(negedge aclk);
    endtask

    task automatic write_key_count(logic [KCOUNT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_key_count(v);
        n_settings++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Load keys 0..n-1 with nondecreasing times and random positions
    task automatic load_table(int n);
        logic [31:0] t;
        longint room;
        int i;
        t = ($urandom_range(3) == 0) ? $urandom : ($urandom >> $urandom_range(31, 1));
        for (i = 0; i < n; i++) begin
            load_key(i[5:0], t, rand_coord(), rand_coord(), rand_coord());
            room = (longint'(32'hFFFF_FFFF) - longint'(t)) / (n - i);
            if (room > 0)
                t = t + ($urandom_range(32'(room), 0) >> $urandom_range(24));
        end
    endtask

    // Pick a sample time: mostly inside the key range, sometimes on a key or outside
    function automatic logic [31:0] pick_time(int n);
        logic [31:0] lo, hi;
        lo = sb.t_tab[0];
        hi = sb.t_tab[n-1];
        case ($urandom_range(19))
            0: return $urandom;
            1: return sb.t_tab[$urandom_range(n - 1)];
            2: return lo - 1;
            default: begin
                if (hi > lo)
                    return $urandom_range(hi, lo);
                return $urandom;
            end
        endcase
    endfunction

    // One random phase: pacing mode, key count, fresh table, then mostly samples
    task automatic run_phase(int pacing, logic [KCOUNT_W-1:0] kc, int items);
        int n, k, slot;
        drain();
        case (pacing)
            0: begin src_idle = 0;  sink_stall = 0;  end
            1: begin src_idle = 66; sink_stall = 0;  end
            2: begin src_idle = 0;  sink_stall = 66; end
            default: begin src_idle = 6; sink_stall = 6; end
        endcase
        write_key_count(kc);
        n = (kc < 1) ? 1 : ((kc > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(kc));
        load_table(n);
        for (k = n; k < items; k++) begin
            if ($urandom_range(15) == 0) begin
                // rewrite a key: a slot in use mostly keeps its time
                slot = $urandom_range(MAX_KEYS_DEF - 1);
                if (slot < n && $urandom_range(3) != 0)
                    load_key(slot[5:0], sb.t_tab[slot], rand_coord(), rand_coord(),
                             rand_coord());
                else
                    load_key(slot[5:0], $urandom, rand_coord(), rand_coord(),
                             rand_coord());
            end else begin
                sample_at(pick_time(n));
            end
        end
    endtask

    initial begin
        logic [31:0] probe[9];
        int ph;
        sb = new();
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        src_idle   = 0;
        sink_stall = 0;
        n_settings = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Single key at the reset key count
        load_key(6'd0, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        sample_at(32'h0000_0100);

        // Five keys: full-scale swings, a decreasing time, a repeated time
        drain();
        write_key_count(7'd5);
        load_key(6'd1, 32'h0000_0400, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        load_key(6'd2, 32'h0000_0300, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678);
        load_key(6'd3, 32'h0000_0300, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
        load_key(6'd4, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        load_key(6'd63, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        probe = '{32'h0, 32'hFF, 32'h100, 32'h101, 32'h3FF, 32'h2A0, 32'h400,
                  32'hFFFF_FFFE, 32'hFFFF_FFFF};
        foreach (probe[i])
            sample_at(probe[i]);

        // Random phases over pacing modes and key counts, extremes included
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0, 5: run_phase(ph % 4, 7'd64, 205);
                2:    run_phase(ph % 4, 7'd127, 205);
                3:    run_phase(ph % 4, 7'd1, 205);
                4:    run_phase(ph % 4, 7'($urandom_range(12, 2)), 205);
                7:    run_phase(ph % 4, 7'd0, 205);
                default: run_phase(ph % 4, 7'($urandom_range(63, 2)), 205);
            endcase
        end

        drain();
        $display("Sent %0d key loads and %0d samples (%0d interpolated, %0d held at key 0)",
                 sb.n_loads, sb.n_samples, sb.n_interp, sb.n_fallback);
        $display("Used %0d key count settings under four pacing modes", n_settings);
        if (sb.errors == 0 && sb.expected_poses.size() == 0)
            $display("tb_keyframe_vec3_sampler: clean");
        else
            $display("tb_keyframe_vec3_sampler: errors");
        $finish;
    end

endmodule
